// ----- rtl/velint_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the 2D velocity integrator.
// No dependencies; the front, queue, back end, top level and checker import this package.
package velint_pkg;

	localparam int DATA_W    = 32;
	localparam int DT_BITS   = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MASS           = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRICTION_COEFF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd4;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic [15:0]        delta_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
	} out_item_t;

	typedef struct packed {
		logic [30:0]        mass;
		logic               gravity_enable;
		logic signed [31:0] gravity;
		logic [30:0]        friction_coeff;
		logic [30:0]        max_speed;
	} cfg_t;

	// Classified step waiting for the back end.
	typedef struct packed {
		logic        force_nz;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		logic [15:0] delta_time;
	} q_entry_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ACC_DIV,
		S_ACC_MX,
		S_ACC_MY,
		S_ACC_AY,
		S_GRAV_MUL,
		S_GRAV_SAT,
		S_GRAV_DT,
		S_GRAV_ADD,
		S_MAG_X,
		S_MAG_Y,
		S_MAG_SUM,
		S_SQRT,
		S_SIZE,
		S_SCL_X,
		S_SCL_Y,
		S_SCL_GO,
		S_SCL_DIV,
		S_OUT
	} back_state_t;

endpackage

// ----- rtl/velint_front.sv -----
`timescale 1ns / 1ps
// Front end: takes input beats and classifies them into queue entries.
// Depends on velint_pkg.
module velint_front
	import velint_pkg::*;
(
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     push,
	output q_entry_t push_entry
);

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_entry.force_nz   = (in_data.force_x != '0) || (in_data.force_y != '0);
		push_entry.neg_x      = in_data.force_x[31];
		push_entry.neg_y      = in_data.force_y[31];
		// Magnitude of the most negative value still fits unsigned.
		push_entry.mag_x      = in_data.force_x[31] ? 32'd0 - 32'(in_data.force_x)
		                                            : 32'(in_data.force_x);
		push_entry.mag_y      = in_data.force_y[31] ? 32'd0 - 32'(in_data.force_y)
		                                            : 32'(in_data.force_y);
		push_entry.delta_time = in_data.delta_time;
	end

endmodule

// ----- rtl/velint_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue between front and back end.
// Depends on velint_pkg.
module velint_queue
	import velint_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     valid,
	output q_entry_t head
);

	q_entry_t    mem_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_entry;
	end

endmodule

// ----- rtl/velint_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 32-bit divisor.
// No package dependencies.
module velint_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        take;

	assign sh       = {rem_q, quo_q[63]};
	assign diff     = sh - {1'b0, dvs_q};
	assign take     = (sh >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 7'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1);
			if (start)              cnt_q <= 7'd64;
			else if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'd0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != 7'd0) begin
			rem_q <= take ? diff[31:0] : sh[31:0];
			quo_q <= {quo_q[62:0], take};
		end
	end

endmodule

// ----- rtl/velint_sqrt.sv -----
`timescale 1ns / 1ps
// Integer square root, one root bit per cycle, floor of sqrt of a 64-bit value.
// No package dependencies.
module velint_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] rem_sh;
	logic [33:0] trial;
	logic        take;

	assign rem_sh = {rem_q[31:0], x_q[63:62]};
	assign trial  = {root_q, 2'b01};
	assign take   = (rem_sh >= trial);
	assign done   = done_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 6'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd0);
			if (start) begin
				cnt_q  <= 6'd31;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= 34'd0;
			root_q <= 32'd0;
		end else if (busy_q) begin
			x_q    <= {x_q[61:0], 2'b00};
			rem_q  <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[30:0], take};
		end
	end

endmodule

// ----- rtl/velint_back.sv -----
`timescale 1ns / 1ps
// Back end: sequencer with one shared multiplier, two dividers and a square root.
// Depends on velint_pkg, velint_div, velint_sqrt.
module velint_back
	import velint_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  q_entry_t  q_head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647)       r = 32'sh7FFFFFFF;
		else if (v < -66'sd2147483648) r = 32'sh80000000;
		else                           r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] apply_sign(input logic neg, input logic [63:0] q);
		logic signed [65:0] s;
		s = $signed({2'b00, q});
		return neg ? sat32(-s) : sat32(s);
	endfunction

	back_state_t state_q, state_d;

	q_entry_t           ent_q;
	logic signed [31:0] vx_w_q, vy_w_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic signed [31:0] vel_x_q, vel_y_q;
	logic signed [31:0] gm_q;
	logic signed [65:0] prod_q;
	logic [63:0]        sumsq_q;
	logic [31:0]        magn_q;
	logic [30:0]        size_q;
	logic [63:0]        sclx_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic               div_start, sqrt_start, mul_en;
	logic signed [32:0] mul_a, mul_b;
	logic [63:0]        dvd_x, dvd_y;
	logic [31:0]        dvs;
	logic               div_done, div_done_y;
	logic [63:0]        quo_x, quo_y;
	logic               sqrt_done;
	logic [31:0]        sqrt_root;
	logic [32:0]        abs_x, abs_y;
	logic [31:0]        fric;
	logic signed [33:0] size_raw, size_cap;
	logic               scale_ok;
	logic               out_free;
	logic               div_both;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign div_both  = div_done && div_done_y;

	assign abs_x = vx_w_q[31] ? 33'd0 - {1'b1, vx_w_q} : {1'b0, vx_w_q};
	assign abs_y = vy_w_q[31] ? 33'd0 - {1'b1, vy_w_q} : {1'b0, vy_w_q};

	// Friction product sits in prod_q from the root step until the size step.
	assign fric     = prod_q[DT_BITS+31:DT_BITS];
	assign size_raw = $signed({2'b00, magn_q}) - $signed({2'b00, fric});
	assign size_cap = (size_raw > $signed({3'b000, cfg.max_speed})) ?
	                  $signed({3'b000, cfg.max_speed}) : size_raw;
	assign scale_ok = (size_cap > 34'sd0) && (magn_q != 32'd0);

	velint_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dvd_x),
		.divisor(dvs), .done(div_done), .quotient(quo_x)
	);

	velint_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dvd_y),
		.divisor(dvs), .done(div_done_y), .quotient(quo_y)
	);

	velint_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.radicand(sumsq_q + prod_q[63:0]), .done(sqrt_done), .root(sqrt_root)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (q_valid) state_d = q_head.force_nz ? S_ACC_DIV : S_GRAV_MUL;
			S_ACC_DIV:  if (div_both) state_d = S_ACC_MX;
			S_ACC_MX:   state_d = S_ACC_MY;
			S_ACC_MY:   state_d = S_ACC_AY;
			S_ACC_AY:   state_d = S_GRAV_MUL;
			S_GRAV_MUL: state_d = cfg.gravity_enable ? S_GRAV_SAT : S_MAG_X;
			S_GRAV_SAT: state_d = S_GRAV_DT;
			S_GRAV_DT:  state_d = S_GRAV_ADD;
			S_GRAV_ADD: state_d = S_MAG_X;
			S_MAG_X:    state_d = S_MAG_Y;
			S_MAG_Y:    state_d = S_MAG_SUM;
			S_MAG_SUM:  state_d = S_SQRT;
			S_SQRT:     if (sqrt_done) state_d = S_SIZE;
			S_SIZE:     state_d = scale_ok ? S_SCL_X : S_OUT;
			S_SCL_X:    state_d = S_SCL_Y;
			S_SCL_Y:    state_d = S_SCL_GO;
			S_SCL_GO:   state_d = S_SCL_DIV;
			S_SCL_DIV:  if (div_both) state_d = S_OUT;
			S_OUT:      if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		mul_en     = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		dvd_x      = 64'(q_head.mag_x) << FRAC_BITS;
		dvd_y      = 64'(q_head.mag_y) << FRAC_BITS;
		dvs        = {1'b0, cfg.mass};
		case (state_q)
			S_IDLE: begin
				q_pop     = q_valid;
				div_start = q_valid && q_head.force_nz;
			end
			S_ACC_MX: begin
				mul_en = 1'b1;
				mul_a  = {acc_x_q[31], acc_x_q};
				mul_b  = {17'd0, ent_q.delta_time};
			end
			S_ACC_MY: begin
				mul_en = 1'b1;
				mul_a  = {acc_y_q[31], acc_y_q};
				mul_b  = {17'd0, ent_q.delta_time};
			end
			S_GRAV_MUL: begin
				mul_en = 1'b1;
				mul_a  = {cfg.gravity[31], cfg.gravity};
				mul_b  = {2'b00, cfg.mass};
			end
			S_GRAV_DT: begin
				mul_en = 1'b1;
				mul_a  = {gm_q[31], gm_q};
				mul_b  = {17'd0, ent_q.delta_time};
			end
			S_MAG_X: begin
				mul_en = 1'b1;
				mul_a  = $signed(abs_x);
				mul_b  = $signed(abs_x);
			end
			S_MAG_Y: begin
				mul_en = 1'b1;
				mul_a  = $signed(abs_y);
				mul_b  = $signed(abs_y);
			end
			S_MAG_SUM: begin
				sqrt_start = 1'b1;
				mul_en     = 1'b1;
				mul_a      = {2'b00, cfg.friction_coeff};
				mul_b      = {17'd0, ent_q.delta_time};
			end
			S_SCL_X: begin
				mul_en = 1'b1;
				mul_a  = $signed(abs_x);
				mul_b  = {2'b00, size_q};
			end
			S_SCL_Y: begin
				mul_en = 1'b1;
				mul_a  = $signed(abs_y);
				mul_b  = {2'b00, size_q};
			end
			S_SCL_GO: begin
				div_start = 1'b1;
				dvd_x     = sclx_q;
				dvd_y     = prod_q[63:0];
				dvs       = magn_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ACC_DIV && div_both) begin
				// Zero component gives zero; zero mass saturates by sign.
				if (ent_q.mag_x == 32'd0)   acc_x_q <= '0;
				else if (cfg.mass == 31'd0) acc_x_q <= ent_q.neg_x ? 32'sh80000000 : 32'sh7FFFFFFF;
				else                        acc_x_q <= apply_sign(ent_q.neg_x, quo_x);
				if (ent_q.mag_y == 32'd0)   acc_y_q <= '0;
				else if (cfg.mass == 31'd0) acc_y_q <= ent_q.neg_y ? 32'sh80000000 : 32'sh7FFFFFFF;
				else                        acc_y_q <= apply_sign(ent_q.neg_y, quo_y);
			end
			if (state_q == S_OUT && out_free) begin
				vel_x_q     <= vx_w_q;
				vel_y_q     <= vy_w_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					ent_q  <= q_head;
					vx_w_q <= vel_x_q;
					vy_w_q <= vel_y_q;
				end
			end
			S_ACC_MY:   vx_w_q  <= sat32(66'(vx_w_q) + (prod_q >>> DT_BITS));
			S_ACC_AY:   vy_w_q  <= sat32(66'(vy_w_q) + (prod_q >>> DT_BITS));
			S_GRAV_SAT: gm_q    <= sat32(prod_q >>> FRAC_BITS);
			S_GRAV_ADD: vy_w_q  <= sat32(66'(vy_w_q) + (prod_q >>> DT_BITS));
			S_MAG_Y:    sumsq_q <= prod_q[63:0];
			S_SQRT:     if (sqrt_done) magn_q <= sqrt_root;
			S_SIZE: begin
				size_q <= size_cap[30:0];
				if (!scale_ok) begin
					vx_w_q <= '0;
					vy_w_q <= '0;
				end
			end
			S_SCL_Y:    sclx_q <= prod_q[63:0];
			S_SCL_DIV: begin
				if (div_both) begin
					vx_w_q <= apply_sign(vx_w_q[31], quo_x);
					vy_w_q <= apply_sign(vy_w_q[31], quo_y);
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_data_q.velocity_x <= vx_w_q;
					out_data_q.velocity_y <= vy_w_q;
					out_data_q.accel_x    <= acc_x_q;
					out_data_q.accel_y    <= acc_y_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/velocity_integrator_2d.sv -----
`timescale 1ns / 1ps
// Top level of the 2D velocity integrator: config registers, front, queue, back.
// Depends on velint_pkg, velint_front, velint_queue, velint_back.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+------------------------------------
//   in      | input     | in_valid / in_stall  | in_item_t: force_x, force_y, delta_time
//   out     | output    | out_valid / out_stall| out_item_t: velocity and acceleration
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every step in the back end takes the 32-bit square root of the magnitude and may
// wait on an output stall; a nonzero force adds the bit-serial divide by mass, gravity
// adds its multiply steps, and a nonzero result speed adds a second divider pass that
// rescales the direction.
// Reset clears velocity and acceleration to zero and loads the config defaults.
// The front keeps taking beats into a two-entry queue while the back end works,
// and a finished result waits in the output register without holding the back end
// until the next result is ready. cfg_ready is always high.
module velocity_integrator_2d
	import velint_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t     cfg_q;
	logic     q_full, q_push, q_pop, q_valid;
	q_entry_t q_push_entry, q_head;

	assign cfg_ready = 1'b1;

	// Hold config registers; writes must arrive only while the block is idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mass           <= 31'(1) << FRAC_BITS;
			cfg_q.gravity_enable <= 1'b0;
			cfg_q.gravity        <= '0;
			cfg_q.friction_coeff <= '0;
			cfg_q.max_speed      <= 31'h7FFFFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MASS:           cfg_q.mass           <= cfg_data[30:0];
				REG_GRAVITY_ENABLE: cfg_q.gravity_enable <= cfg_data[0];
				REG_GRAVITY:        cfg_q.gravity        <= cfg_data;
				REG_FRICTION_COEFF: cfg_q.friction_coeff <= cfg_data[30:0];
				REG_MAX_SPEED:      cfg_q.max_speed      <= cfg_data[30:0];
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	// Classify incoming beats: force present, signs and magnitudes.
	velint_front u_front (
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.q_full(q_full), .push(q_push), .push_entry(q_push_entry)
	);

	// Decouple front and back so each side stalls on its own.
	velint_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_entry(q_push_entry),
		.full(q_full), .pop(q_pop), .valid(q_valid), .head(q_head)
	);

	// Advance one step at a time through the shared arithmetic units.
	velint_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_head(q_head),
		.q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

// ----- rtl/velint_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the 2D velocity integrator, bound to the top level.
// Depends on velint_pkg and velocity_integrator_2d.
module velint_chk
	import velint_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input out_item_t            out_data,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	logic [2:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 3'd0)
		else $error("result without a pending step");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd4 |-> in_stall)
		else $error("beat taken beyond internal capacity");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind velocity_integrator_2d velint_chk u_chk (.*);
